// File: design/som_bmu_search_and_update_core_macros.svh
// Assertion macros for the SOM search-and-update block.
// Used by som_bmu_search_and_update_core; no other dependencies.
`ifndef SOM_BMU_SEARCH_AND_UPDATE_CORE_MACROS_SVH
`define SOM_BMU_SEARCH_AND_UPDATE_CORE_MACROS_SVH

// same-cycle implication
`define SOM_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("som_bmu assertion failed");

// next-cycle implication
`define SOM_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("som_bmu assertion failed");

`endif

// File: design/som_bmu_pkg.sv
// Package for the SOM search-and-update block: transaction types, codes, states.
// No dependencies.
package som_bmu_pkg;

   localparam int LATTICE_COLS_DEF = 16;
   localparam int LATTICE_ROWS_DEF = 4;
   localparam int VECTOR_DIM_DEF   = 3;
   localparam int COORD_W          = 6;
   localparam int DIST_W           = 34;
   localparam int ACC_W            = 36;
   localparam int DIV_W            = 32;
   localparam int DEN_W            = 19;
   localparam int MUL_A_W          = 17;
   localparam int MUL_B_W          = 32;
   localparam int MUL_P_W          = MUL_A_W + MUL_B_W;
   localparam int HORNER_TERMS     = 6;

   localparam logic [1:0] OP_LOAD     = 2'd0;
   localparam logic [1:0] OP_TRAIN    = 2'd1;
   localparam logic [1:0] OP_CLASSIFY = 2'd2;
   localparam logic [1:0] OP_RESERVED = 2'd3;

   typedef struct packed {
      logic [1:0]         operation;
      logic [5:0]         neuron_index;
      logic signed [15:0] component_0;
      logic signed [15:0] component_1;
      logic signed [15:0] component_2;
      logic [15:0]        learning_rate;
      logic [15:0]        neigh_width;
   } req_type;

   typedef struct packed {
      logic [3:0]  bmu_x;
      logic [1:0]  bmu_y;
      logic [33:0] min_distance_sq;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_LOAD,
      ST_SCAN_RD,
      ST_SCAN_SQ,
      ST_SCAN_ACC,
      ST_GATE,
      ST_TDIV,
      ST_HMUL,
      ST_HSTART,
      ST_HDIV,
      ST_GAIN,
      ST_GLATCH,
      ST_URD,
      ST_UMUL,
      ST_UWR,
      ST_DONE
   } state_type;

endpackage

// File: design/som_bmu_search_and_update_core.sv
// Self-organizing map: best-matching-unit search and training step.
// Channels: req_* carries one transaction (load, train or classify), rsp_* returns
// one result per request; both valid/ready, accepted when valid and ready are high.
// The block works on one request at a time; req_ready is high only while idle.
// Operation with N = LATTICE_COLS*LATTICE_ROWS neurons and D = VECTOR_DIM:
//   load:     D weight writes for an index below N (one weight write per cycle).
//   classify: N*D components, each read through the single weight RAM read
//             port and squared by one shared multiplier, one at a time.
//   train:    classify, then a neighborhood check per neuron; each neuron inside
//             it runs the 32-step shared divider once for the exponent argument
//             and once for each of the six series terms, then rewrites its D weights.
// The result sits in an output register; the next request can be accepted
// while it waits. A finished request holds in ST_DONE while an earlier result
// is still stalled by rsp_ready low.
// Reset (synchronous, active high) clears control state only; weights are
// undefined until loaded, so every neuron must be loaded before searching.
// Depends on som_bmu_pkg, som_bmu_ram and the assertion macro header.
`include "som_bmu_search_and_update_core_macros.svh"

module som_bmu_search_and_update_core
   import som_bmu_pkg::*;
#(
   parameter int LATTICE_COLS = LATTICE_COLS_DEF,
   parameter int LATTICE_ROWS = LATTICE_ROWS_DEF,
   parameter int VECTOR_DIM   = VECTOR_DIM_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);
   localparam int NEURONS = LATTICE_COLS * LATTICE_ROWS;
   localparam int DEPTH   = NEURONS * VECTOR_DIM;
   localparam int AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CIW     = (VECTOR_DIM > 1) ? $clog2(VECTOR_DIM) : 1;
   localparam logic [COORD_W-1:0] COL_LAST = COORD_W'(LATTICE_COLS - 1);
   localparam logic [COORD_W-1:0] ROW_LAST = COORD_W'(LATTICE_ROWS - 1);
   localparam logic [CIW-1:0]     C_LAST   = CIW'(VECTOR_DIM - 1);
   localparam logic [AW-1:0]      A_STEP   = AW'(VECTOR_DIM);

   state_type            state_ff, state_in;
   req_type              req_ff, req_in;
   logic [AW-1:0]        addr_ff, addr_in;
   logic [CIW-1:0]       c_ff, c_in;
   logic [COORD_W-1:0]   col_ff, col_in, row_ff, row_in;
   logic [COORD_W-1:0]   bx_ff, bx_in, by_ff, by_in;
   logic [ACC_W-1:0]     dist_ff, dist_in, best_ff, best_in;
   logic                 found_ff, found_in;
   logic [MUL_P_W-1:0]   prod_ff, prod_in;
   logic [15:0]          t_ff, t_in;
   logic [16:0]          acc_ff, acc_in;
   logic [2:0]           k_ff, k_in;
   logic [31:0]          g_ff, g_in;
   logic                 neg_ff, neg_in;
   logic signed [15:0]   w_ff, w_in;
   logic [DEN_W:0]       rem_ff, rem_in;
   logic [DIV_W-1:0]     quo_ff, quo_in;
   logic [DEN_W-1:0]     den_ff, den_in;
   logic [5:0]           dcnt_ff, dcnt_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_ff, rsp_in;

   logic                 we;
   logic [15:0]          wdata;
   logic [15:0]          rdata;
   logic [MUL_A_W-1:0]   mul_a;
   logic [MUL_B_W-1:0]   mul_b;
   logic [MUL_P_W-1:0]   mul_p;
   logic signed [15:0]   xc;
   logic signed [16:0]   diff;
   logic [16:0]          mag;
   logic [ACC_W-1:0]     sum;
   logic                 last_n;
   logic signed [6:0]    dx, dy;
   logic [13:0]          d2;
   logic [DEN_W:0]       rem_sh;
   logic [49:0]          rnd;
   logic [17:0]          dm;
   logic signed [19:0]   wnew;
   logic signed [15:0]   wsat;

   som_bmu_ram #(.WIDTH(16), .DEPTH(DEPTH)) u_ram (
      .clock   (clock),
      .wr_en   (we),
      .wr_addr (addr_ff),
      .wr_data (wdata),
      .rd_addr (addr_ff),
      .rd_data (rdata)
   );

   assign mul_p = MUL_P_W'(mul_a) * MUL_P_W'(mul_b);

   always_comb begin
      if (32'(c_ff) == 32'd0) begin
         xc = req_ff.component_0;
      end else if (32'(c_ff) == 32'd1) begin
         xc = req_ff.component_1;
      end else if (32'(c_ff) == 32'd2) begin
         xc = req_ff.component_2;
      end else begin
         xc = '0;
      end
   end

   assign diff   = {xc[15], xc} - {rdata[15], rdata};
   assign mag    = diff[16] ? 17'(-diff) : 17'(diff);
   assign sum    = dist_ff + prod_ff[ACC_W-1:0];
   assign last_n = (col_ff == COL_LAST) && (row_ff == ROW_LAST);
   assign dx     = 7'(signed'({1'b0, col_ff})) - 7'(signed'({1'b0, bx_ff}));
   assign dy     = 7'(signed'({1'b0, row_ff})) - 7'(signed'({1'b0, by_ff}));
   assign d2     = 14'(14'(dx) * 14'(dx)) + 14'(14'(dy) * 14'(dy));
   assign rem_sh = {rem_ff[DEN_W-1:0], quo_ff[DIV_W-1]};
   assign rnd    = 50'(prod_ff) + 50'(64'h8000_0000);
   assign dm     = rnd[49:32];
   assign wnew   = 20'(w_ff) + (neg_ff ? -20'(signed'({2'b0, dm})) : 20'(signed'({2'b0, dm})));
   assign wsat   = (wnew > 20'sd32767) ? 16'sh7fff :
                   (wnew < -20'sd32768) ? -16'sh8000 : 16'(wnew);

   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      addr_in      = addr_ff;
      c_in         = c_ff;
      col_in       = col_ff;
      row_in       = row_ff;
      bx_in        = bx_ff;
      by_in        = by_ff;
      dist_in      = dist_ff;
      best_in      = best_ff;
      found_in     = found_ff;
      prod_in      = prod_ff;
      t_in         = t_ff;
      acc_in       = acc_ff;
      k_in         = k_ff;
      g_in         = g_ff;
      neg_in       = neg_ff;
      w_in         = w_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      den_in       = den_ff;
      dcnt_in      = dcnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      req_ready    = 1'b0;
      we           = 1'b0;
      wdata        = xc;
      mul_a        = '0;
      mul_b        = '0;

      // divider step
      if (dcnt_ff != '0) begin
         dcnt_in = dcnt_ff - 6'd1;
         if (rem_sh >= {1'b0, den_ff}) begin
            rem_in = rem_sh - {1'b0, den_ff};
            quo_in = {quo_ff[DIV_W-2:0], 1'b1};
         end else begin
            rem_in = rem_sh;
            quo_in = {quo_ff[DIV_W-2:0], 1'b0};
         end
      end

      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               req_in = req_data;
               c_in   = '0;
               if (req_data.operation == OP_LOAD) begin
                  addr_in = AW'(32'(req_data.neuron_index) * VECTOR_DIM);
                  if (32'(req_data.neuron_index) < NEURONS) begin
                     state_in = ST_LOAD;
                  end else begin
                     state_in = ST_DONE;
                  end
               end else begin
                  addr_in  = '0;
                  col_in   = '0;
                  row_in   = '0;
                  found_in = 1'b0;
                  dist_in  = '0;
                  state_in = ST_SCAN_RD;
               end
            end
         end
         ST_LOAD: begin
            we      = 1'b1;
            addr_in = addr_ff + AW'(1);
            c_in    = c_ff + CIW'(1);
            if (c_ff == C_LAST) begin
               state_in = ST_DONE;
            end
         end
         ST_SCAN_RD: begin
            state_in = ST_SCAN_SQ;
         end
         ST_SCAN_SQ: begin
            mul_a    = mag;
            mul_b    = 32'(mag);
            prod_in  = mul_p;
            state_in = ST_SCAN_ACC;
         end
         ST_SCAN_ACC: begin
            addr_in = addr_ff + AW'(1);
            if (c_ff == C_LAST) begin
               if (!found_ff || sum < best_ff) begin
                  best_in  = sum;
                  bx_in    = col_ff;
                  by_in    = row_ff;
                  found_in = 1'b1;
               end
               dist_in = '0;
               c_in    = '0;
               col_in  = (col_ff == COL_LAST) ? '0 : col_ff + COORD_W'(1);
               row_in  = (col_ff == COL_LAST) ? row_ff + COORD_W'(1) : row_ff;
               if (last_n) begin
                  if (req_ff.operation == OP_TRAIN) begin
                     addr_in  = '0;
                     col_in   = '0;
                     row_in   = '0;
                     state_in = ST_GATE;
                  end else begin
                     state_in = ST_DONE;
                  end
               end else begin
                  state_in = ST_SCAN_RD;
               end
            end else begin
               dist_in  = sum;
               c_in     = c_ff + CIW'(1);
               state_in = ST_SCAN_RD;
            end
         end
         ST_GATE: begin
            c_in = '0;
            if ({d2, 8'b0} < {6'b0, req_ff.neigh_width}) begin
               rem_in   = '0;
               quo_in   = {d2[7:0], 24'b0};
               den_in   = DEN_W'({req_ff.neigh_width, 1'b0});
               dcnt_in  = 6'(DIV_W);
               state_in = ST_TDIV;
            end else begin
               addr_in = addr_ff + A_STEP;
               col_in  = (col_ff == COL_LAST) ? '0 : col_ff + COORD_W'(1);
               row_in  = (col_ff == COL_LAST) ? row_ff + COORD_W'(1) : row_ff;
               if (last_n) begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_TDIV: begin
            if (dcnt_ff == '0) begin
               t_in     = quo_ff[15:0];
               acc_in   = 17'h10000;
               k_in     = 3'(HORNER_TERMS);
               state_in = ST_HMUL;
            end
         end
         ST_HMUL: begin
            mul_a    = acc_ff;
            mul_b    = 32'(t_ff);
            prod_in  = mul_p;
            state_in = ST_HSTART;
         end
         ST_HSTART: begin
            rem_in   = '0;
            quo_in   = prod_ff[31:0] + {14'b0, k_ff, 15'b0};
            den_in   = {k_ff, 16'b0};
            dcnt_in  = 6'(DIV_W);
            state_in = ST_HDIV;
         end
         ST_HDIV: begin
            if (dcnt_ff == '0) begin
               acc_in = (quo_ff >= 32'h10000) ? '0 : 17'(33'h10000 - 33'(quo_ff));
               k_in   = k_ff - 3'd1;
               if (k_ff == 3'd1) begin
                  state_in = ST_GAIN;
               end else begin
                  state_in = ST_HMUL;
               end
            end
         end
         ST_GAIN: begin
            mul_a    = acc_ff;
            mul_b    = 32'(req_ff.learning_rate);
            prod_in  = mul_p;
            state_in = ST_GLATCH;
         end
         ST_GLATCH: begin
            g_in     = prod_ff[31:0];
            state_in = ST_URD;
         end
         ST_URD: begin
            state_in = ST_UMUL;
         end
         ST_UMUL: begin
            neg_in   = diff[16];
            w_in     = signed'(rdata);
            mul_a    = mag;
            mul_b    = g_ff;
            prod_in  = mul_p;
            state_in = ST_UWR;
         end
         ST_UWR: begin
            we      = 1'b1;
            wdata   = wsat;
            addr_in = addr_ff + AW'(1);
            if (c_ff == C_LAST) begin
               c_in   = '0;
               col_in = (col_ff == COL_LAST) ? '0 : col_ff + COORD_W'(1);
               row_in = (col_ff == COL_LAST) ? row_ff + COORD_W'(1) : row_ff;
               if (last_n) begin
                  state_in = ST_DONE;
               end else begin
                  state_in = ST_GATE;
               end
            end else begin
               c_in     = c_ff + CIW'(1);
               state_in = ST_URD;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               if (req_ff.operation == OP_LOAD) begin
                  rsp_in = '0;
               end else begin
                  rsp_in.bmu_x = bx_ff[3:0];
                  rsp_in.bmu_y = by_ff[1:0];
                  rsp_in.min_distance_sq = (best_ff > ACC_W'({DIST_W{1'b1}})) ?
                     {DIST_W{1'b1}} : best_ff[DIST_W-1:0];
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         dcnt_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         dcnt_ff      <= dcnt_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff   <= req_in;
      addr_ff  <= addr_in;
      c_ff     <= c_in;
      col_ff   <= col_in;
      row_ff   <= row_in;
      bx_ff    <= bx_in;
      by_ff    <= by_in;
      dist_ff  <= dist_in;
      best_ff  <= best_in;
      found_ff <= found_in;
      prod_ff  <= prod_in;
      t_ff     <= t_in;
      acc_ff   <= acc_in;
      k_ff     <= k_in;
      g_ff     <= g_in;
      neg_ff   <= neg_in;
      w_ff     <= w_in;
      rem_ff   <= rem_in;
      quo_ff   <= quo_in;
      den_ff   <= den_in;
      rsp_ff   <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   `SOM_ASSERT_IMP(a_we_state, clock, reset, we, (state_ff == ST_LOAD || state_ff == ST_UWR))
   `SOM_ASSERT_NXT(a_busy_after_req, clock, reset, req_valid && req_ready, !req_ready)
   `SOM_ASSERT_IMP(a_horner_k, clock, reset, (state_ff == ST_HMUL || state_ff == ST_HDIV),
                   (k_ff >= 3'd1 && k_ff <= 3'(HORNER_TERMS)))
endmodule

// File: design/som_bmu_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module som_bmu_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 192
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule
